@@ rtl/dercr_pkg.sv @@
// ----------------------------------------------------------------------------
// Directory-entry cache package
// Sizes, register indexes, operation codes and beat types shared by the
// directory-entry cache tag store.
// ----------------------------------------------------------------------------
package dercr_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam int ID_W     = 48;
  localparam int SLOT_W   = 6;
  localparam int BSL_W    = 4;
  localparam int BLK_W    = 39;
  localparam int OFF_W    = 15;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  localparam logic REG_ROOT_ID         = 1'b0;
  localparam logic REG_BLOCK_SIZE_LOG2 = 1'b1;

  localparam logic [BSL_W-1:0] BSL_RESET = 4'd11;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              fill_ok;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot_index;
    logic              from_root;
    logic              need_fetch;
    logic [BLK_W-1:0]  block_address;
    logic [OFF_W-1:0]  byte_offset;
  } out_item_t;

endpackage

@@ rtl/dir_entry_cache_round_robin.sv @@
// ----------------------------------------------------------------------------
// Directory-entry cache tag store
// Fully associative tag store with first-free allocation and round-robin
// replacement, scanned one tag per cycle through a dual-port tag memory.
// ----------------------------------------------------------------------------
// A fill beat is answered in the cycle after acceptance; a lookup compares
// slots from zero up with one tag memory read per cycle until a hit or miss.
// One beat is in flight at a time and the input stalls until the result leaves;
// a miss holds the block until all slots are scanned and its result has left.
// Reset clears the per-slot valid bits so every slot reads as free, with no
// clearing pass; the replacement pointer resets to slot zero.
module dir_entry_cache_round_robin (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dercr_pkg::in_item_t        in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dercr_pkg::out_item_t       out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dercr_pkg::PADDR_W-1:0] paddr,
  input  logic [dercr_pkg::PDATA_W-1:0] pwdata,
  output logic [dercr_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);
  import dercr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  rd_addr_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [ID_W-1:0]   id_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;
  logic [IDX_W-1:0]  ptr_q;
  out_item_t         out_q;

  logic [ID_W-1:0]   root_q;
  logic [BSL_W-1:0]  bsl_q;

  logic [ID_W-1:0]   mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [ID_W-1:0]   rd_data_q;
  logic              rd_vld_q;

  logic              in_acc;
  logic              cfg_wr;
  logic [ID_W-1:0]   cur_tag;
  logic              cur_match;
  logic              cur_free;
  logic              last_cmp;
  logic              miss_done;
  logic              have_free;
  logic [IDX_W-1:0]  victim;
  logic [IDX_W-1:0]  ptr_next;
  logic              is_root;
  logic [ID_W-1:0]   shifted;
  logic [OFF_W-1:0]  off_mask;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [ID_W-1:0]   mem_wd;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3])
      REG_ROOT_ID:         prdata = PDATA_W'(root_q);
      REG_BLOCK_SIZE_LOG2: prdata = PDATA_W'(bsl_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      bsl_q  <= BSL_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_ROOT_ID:         root_q <= pwdata[ID_W-1:0];
        REG_BLOCK_SIZE_LOG2: bsl_q  <= pwdata[BSL_W-1:0];
        default:             root_q <= root_q;
      endcase
    end
  end

  assign cur_tag   = rd_vld_q ? rd_data_q : '0;
  assign cur_match = cmp_vld_q && (cur_tag == id_q);
  assign cur_free  = cmp_vld_q && (cur_tag == '0);
  assign last_cmp  = cmp_vld_q && (cmp_idx_q == IDX_W'(ENTRIES - 1));
  assign miss_done = (state_q == ST_SCAN) && last_cmp && !cur_match;
  assign have_free = free_q || cur_free;
  assign victim    = free_q ? free_idx_q : (cur_free ? cmp_idx_q : ptr_q);
  assign ptr_next  = (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
  assign is_root   = (id_q == root_q);
  assign shifted   = id_q >> bsl_q;
  assign off_mask  = OFF_W'((16'd1 << bsl_q) - 16'd1);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = victim;
    mem_wd = id_q;
    if (in_acc && (in_data_i.opcode == OP_FILL)) begin
      mem_we = in_data_i.fill_ok && (32'(in_data_i.slot) < ENTRIES);
      mem_wa = IDX_W'(in_data_i.slot);
      mem_wd = in_data_i.id;
    end else if (miss_done && is_root) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr_q];
    rd_vld_q  <= vld_q[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_addr_q  <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      ptr_q      <= '0;
      id_q       <= '0;
      out_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cmp_vld_q <= 1'b0;
          if (in_valid_i) begin
            id_q <= in_data_i.id;
            if (in_data_i.opcode == OP_FILL) begin
              out_q            <= '0;
              out_q.slot_index <= in_data_i.slot;
              state_q          <= ST_OUT;
            end else begin
              rd_addr_q <= '0;
              free_q    <= 1'b0;
              state_q   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= 1'b1;
          cmp_idx_q <= rd_addr_q;
          if (rd_addr_q != IDX_W'(ENTRIES - 1)) begin
            rd_addr_q <= rd_addr_q + 1'b1;
          end
          if (cur_match) begin
            out_q            <= '0;
            out_q.hit        <= 1'b1;
            out_q.slot_index <= SLOT_W'(cmp_idx_q);
            cmp_vld_q        <= 1'b0;
            state_q          <= ST_OUT;
          end else begin
            if (cur_free && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
            if (last_cmp) begin
              out_q            <= '0;
              out_q.slot_index <= SLOT_W'(victim);
              if (is_root) begin
                out_q.from_root <= 1'b1;
              end else begin
                out_q.need_fetch    <= 1'b1;
                out_q.block_address <= shifted[BLK_W-1:0];
                out_q.byte_offset   <= id_q[OFF_W-1:0] & off_mask;
              end
              if (!have_free) begin
                ptr_q <= ptr_next;
              end
              cmp_vld_q <= 1'b0;
              state_q   <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_answers_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.opcode == OP_FILL)) |=> out_valid_o)
    else $error("fill beat not answered in the next cycle");

  a_hit_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> (!out_data_o.need_fetch && !out_data_o.from_root))
    else $error("hit result also requests a fetch or a root fill");

  a_root_xor_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.from_root && out_data_o.need_fetch))
    else $error("result marks both a root fill and a fetch");

  a_ptr_moves_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q != $past(ptr_q)) |-> ($past(state_q) == ST_SCAN))
    else $error("replacement pointer moved outside a lookup");

endmodule
